// ===== hdl/lrr_pkg.sv =====
// Shared constants and helpers for the line run rasterizer.
`timescale 1ns / 1ps
package lrr_pkg;

	localparam int COORD_BITS_DEF = 9;
	localparam int COLOR_BITS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_NEXT = 1'b1;

	// Width of one queued command: three flags, five coordinates and the color.
	function automatic int cmd_bits(input int coord_bits);
		return 3 + 5 * coord_bits + COLOR_BITS;
	endfunction

	function automatic int byte_fill(input int bits);
		return ((bits + 7) / 8) * 8;
	endfunction

endpackage

// ===== hdl/lrr_front.sv =====
// Front end: accepts request beats and turns each into a queued command, with line setup for start requests.
`timescale 1ns / 1ps
module lrr_front
	import lrr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_req,
	input  logic [COORD_BITS-1:0]               in_x1,
	input  logic [COORD_BITS-1:0]               in_y1,
	input  logic [COORD_BITS-1:0]               in_x2,
	input  logic [COORD_BITS-1:0]               in_y2,
	input  logic [COLOR_BITS-1:0]               in_color,
	output logic                                push,
	output logic [cmd_bits(COORD_BITS)-1:0]     push_data,
	input  logic                                full
);

	typedef struct packed {
		logic                  is_start;
		logic                  swapped;
		logic                  minor_down;
		logic [COORD_BITS-1:0] major_pos;
		logic [COORD_BITS-1:0] major_end;
		logic [COORD_BITS-1:0] minor_pos;
		logic [COORD_BITS-1:0] delta_major;
		logic [COORD_BITS-1:0] delta_minor;
		logic [COLOR_BITS-1:0] color;
	} cmd_t;

	logic                  valid_s1;
	logic                  req_s1;
	logic [COORD_BITS-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic [COORD_BITS-1:0] adx, ady;
	logic                  swapped;
	logic [COORD_BITS-1:0] ma1, mi1, ma2, mi2;
	logic [COORD_BITS-1:0] mas, mis, mae, mie;
	cmd_t                  cmd;

	assign in_ready = !valid_s1 || !full;
	assign push = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
			x1_s1 <= in_x1;
			y1_s1 <= in_y1;
			x2_s1 <= in_x2;
			y2_s1 <= in_y2;
			color_s1 <= in_color;
		end
	end

	always_comb begin
		adx = (x2_s1 > x1_s1) ? x2_s1 - x1_s1 : x1_s1 - x2_s1;
		ady = (y2_s1 > y1_s1) ? y2_s1 - y1_s1 : y1_s1 - y2_s1;
		swapped = ady > adx;
		ma1 = swapped ? y1_s1 : x1_s1;
		mi1 = swapped ? x1_s1 : y1_s1;
		ma2 = swapped ? y2_s1 : x2_s1;
		mi2 = swapped ? x2_s1 : y2_s1;
		if (ma1 > ma2) begin
			mas = ma2;
			mis = mi2;
			mae = ma1;
			mie = mi1;
		end else begin
			mas = ma1;
			mis = mi1;
			mae = ma2;
			mie = mi2;
		end
		cmd.is_start = (req_s1 == REQ_START);
		cmd.swapped = swapped;
		cmd.minor_down = mis < mie;
		cmd.major_pos = mas;
		cmd.major_end = mae;
		cmd.minor_pos = mis;
		cmd.delta_major = mae - mas;
		cmd.delta_minor = (mie > mis) ? mie - mis : mis - mie;
		cmd.color = color_s1;
	end

	assign push_data = cmd;

endmodule

// ===== hdl/lrr_fifo.sv =====
// Short command queue between the front end and the run stepper.
`timescale 1ns / 1ps
module lrr_fifo
	import lrr_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/lrr_back.sv =====
// Back end: holds the line state, steps one pixel a cycle within a run and registers each run.
`timescale 1ns / 1ps
module lrr_back
	import lrr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            empty,
	output logic                            pop,
	input  logic [cmd_bits(COORD_BITS)-1:0] pop_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [COORD_BITS-1:0]           out_x,
	output logic [COORD_BITS-1:0]           out_y,
	output logic [COORD_BITS:0]             out_len,
	output logic                            out_vertical,
	output logic [COLOR_BITS-1:0]           out_color,
	output logic                            out_last
);

	localparam int ERR_W = COORD_BITS + 2;

	typedef struct packed {
		logic                  is_start;
		logic                  swapped;
		logic                  minor_down;
		logic [COORD_BITS-1:0] major_pos;
		logic [COORD_BITS-1:0] major_end;
		logic [COORD_BITS-1:0] minor_pos;
		logic [COORD_BITS-1:0] delta_major;
		logic [COORD_BITS-1:0] delta_minor;
		logic [COLOR_BITS-1:0] color;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd;
	logic                     active_q;
	logic                     swapped_q;
	logic                     down_q;
	logic [COORD_BITS-1:0]    major_q, minor_q, end_q, dmaj_q, dmin_q;
	logic signed [ERR_W-1:0]  err_q;
	logic [COLOR_BITS-1:0]    color_q;
	logic [COORD_BITS-1:0]    first_major_q, first_minor_q;
	logic [COORD_BITS:0]      len_q;
	logic                     last_q;

	logic signed [ERR_W-1:0]  err_sub, err_new;
	logic                     stepped, at_end;
	logic [COORD_BITS-1:0]    minor_new;
	logic [COORD_BITS:0]      len_new;
	logic                     emit_go;

	assign cmd = pop_data;
	assign pop = (state_q == ST_IDLE) && !empty;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid || out_ready);

	always_comb begin
		err_sub = err_q - $signed({2'b00, dmin_q});
		stepped = err_sub[ERR_W-1];
		err_new = stepped ? err_sub + $signed({2'b00, dmaj_q}) : err_sub;
		minor_new = stepped ? (down_q ? minor_q + 1'b1 : minor_q - 1'b1) : minor_q;
		at_end = major_q == end_q;
		len_new = len_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			swapped_q <= 1'b0;
			down_q <= 1'b0;
			major_q <= '0;
			minor_q <= '0;
			end_q <= '0;
			dmaj_q <= '0;
			dmin_q <= '0;
			err_q <= '0;
			color_q <= '0;
			first_major_q <= '0;
			first_minor_q <= '0;
			len_q <= '0;
			last_q <= 1'b0;
			out_valid <= 1'b0;
			out_x <= '0;
			out_y <= '0;
			out_len <= '0;
			out_vertical <= 1'b0;
			out_color <= '0;
			out_last <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (cmd.is_start) begin
							active_q <= 1'b1;
							swapped_q <= cmd.swapped;
							down_q <= cmd.minor_down;
							major_q <= cmd.major_pos;
							minor_q <= cmd.minor_pos;
							end_q <= cmd.major_end;
							dmaj_q <= cmd.delta_major;
							dmin_q <= cmd.delta_minor;
							err_q <= $signed({3'b000, cmd.delta_major[COORD_BITS-1:1]});
							color_q <= cmd.color;
							first_major_q <= cmd.major_pos;
							first_minor_q <= cmd.minor_pos;
							len_q <= '0;
							state_q <= ST_RUN;
						end else if (active_q) begin
							first_major_q <= major_q;
							first_minor_q <= minor_q;
							len_q <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					len_q <= len_new;
					err_q <= err_new;
					minor_q <= minor_new;
					last_q <= at_end;
					if (at_end) begin
						active_q <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						major_q <= major_q + 1'b1;
						if (stepped) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_x <= swapped_q ? first_minor_q : first_major_q;
						out_y <= swapped_q ? first_major_q : first_minor_q;
						out_len <= len_q;
						out_vertical <= swapped_q;
						out_color <= color_q;
						out_last <= last_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_run_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> active_q)
		else $error("Stepping a run while no line is active.");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && last_q) |-> !active_q)
		else $error("The final run left the line active.");

	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (len_q != '0))
		else $error("A run of zero pixels reached the output stage.");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> (state_q != ST_IDLE))
		else $error("A run skipped the output stage.");

endmodule

// ===== hdl/line_run_rasterizer_top.sv =====
// Top level of the line run rasterizer: stream ports and beat packing.
//
// The slave channel takes request beats. tuser carries the request kind: a
// start beat latches both endpoints and the color and returns the first run;
// a next beat returns the following run of the current line and is dropped
// without a result when no line is active. A start abandons any line in work.
// The master channel gives one beat per run with tlast set on the final run.
// The stepper walks a run one pixel per cycle on the major axis; a request
// passes through the input register, the command queue, the stepper and the
// output register before its result appears.
// The stepper handles one request at a time and takes the next from the queue
// only once it has handed its current run to the output register.
// Two commands can wait in the queue while the stepper works, and the input
// register holds a third. When the receiver stalls, the finished run waits in
// the output register, the stepper holds its next run, and the queue fills
// until tready falls. Reset clears the line state, the queue and all valids.
`timescale 1ns / 1ps
module line_run_rasterizer_top
	import lrr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// start_x, start_y, end_x, end_y, pixel_color, then zero fill
	input  logic [byte_fill(4*COORD_BITS+COLOR_BITS)-1:0] s_tdata,
	// req_type
	input  logic                                         s_tuser,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// run_x, run_y, run_len, run_vertical, run_color, then zero fill
	output logic [byte_fill(3*COORD_BITS+1+COLOR_BITS+1)-1:0] m_tdata,
	// last_run
	output logic                                         m_tlast
);

	localparam int C = COORD_BITS;
	localparam int IN_W = byte_fill(4 * C + COLOR_BITS);
	localparam int OUT_USED = 3 * C + 2 + COLOR_BITS;
	localparam int OUT_W = byte_fill(OUT_USED);
	localparam int CMD_W = cmd_bits(C);

	logic             push, full, pop, empty;
	logic [CMD_W-1:0] push_data, pop_data;
	logic [C-1:0]     run_x, run_y;
	logic [C:0]       run_len;
	logic             run_vertical;
	logic [COLOR_BITS-1:0] run_color;
	logic [IN_W-1:0]  in_bits;

	assign in_bits = s_tdata;

	lrr_front #(.COORD_BITS(C)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_x1     (in_bits[C-1:0]),
		.in_y1     (in_bits[2*C-1:C]),
		.in_x2     (in_bits[3*C-1:2*C]),
		.in_y2     (in_bits[4*C-1:3*C]),
		.in_color  (in_bits[4*C+COLOR_BITS-1:4*C]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lrr_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	lrr_back #(.COORD_BITS(C)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop          (pop),
		.pop_data     (pop_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_x        (run_x),
		.out_y        (run_y),
		.out_len      (run_len),
		.out_vertical (run_vertical),
		.out_color    (run_color),
		.out_last     (m_tlast)
	);

	assign m_tdata = OUT_W'({run_color, run_vertical, run_len, run_y, run_x});

endmodule

// ===== test/line_run_rasterizer_top_tb.sv =====
// Self-checking testbench for the line run rasterizer: run prediction, random lines and stalls.
`timescale 1ns / 1ps
module line_run_rasterizer_top_tb;
	import lrr_pkg::*;

	localparam int IN_W = byte_fill(4 * 9 + COLOR_BITS);
	localparam int OUT_W = byte_fill(3 * 9 + 1 + COLOR_BITS + 1);
	localparam int ITEM_TARGET = 900;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 600;
	localparam int STALL_LIMIT = 20000;

	class run_scoreboard;
		typedef struct packed {
			logic [8:0] x;
			logic [8:0] y;
			logic [9:0] len;
			logic vertical;
			logic [15:0] color;
			logic last;
		} run_t;

		bit line_active = 1'b0;
		bit axes_swapped = 1'b0;
		logic [8:0] major_pos = '0;
		logic [8:0] minor_pos = '0;
		logic [8:0] major_end = '0;
		logic [8:0] delta_major = '0;
		logic [8:0] delta_minor = '0;
		logic signed [10:0] error_term = '0;
		bit minor_down = 1'b0;
		logic [15:0] line_color = '0;
		run_t expected_runs[$];
		int errors = 0;

		task report(string msg);
			if (errors < 40) begin
				$display("mismatch at %0t ns: %s", $realtime, msg);
			end
			errors++;
		endtask

		// Advances the stepper over one request and queues the run it yields.
		function void note_request(logic req, logic [8:0] sx, logic [8:0] sy,
				logic [8:0] ex, logic [8:0] ey, logic [15:0] color);
			logic [8:0] a1, b1, a2, b2, t, adx, ady, first_major, first_minor;
			logic [9:0] len;
			bit stepped, run_over, last;
			run_t r;
			if (req == REQ_START) begin
				adx = (ex > sx) ? ex - sx : sx - ex;
				ady = (ey > sy) ? ey - sy : sy - ey;
				axes_swapped = ady > adx;
				if (axes_swapped) begin
					a1 = sy; b1 = sx; a2 = ey; b2 = ex;
				end else begin
					a1 = sx; b1 = sy; a2 = ex; b2 = ey;
				end
				if (a1 > a2) begin
					t = a1; a1 = a2; a2 = t;
					t = b1; b1 = b2; b2 = t;
				end
				major_pos = a1;
				major_end = a2;
				minor_pos = b1;
				delta_major = a2 - a1;
				delta_minor = (b2 > b1) ? b2 - b1 : b1 - b2;
				minor_down = b1 < b2;
				error_term = {3'b000, delta_major[8:1]};
				line_color = color;
				line_active = 1'b1;
			end else if (!line_active) begin
				return;
			end
			first_major = major_pos;
			first_minor = minor_pos;
			len = '0;
			last = 1'b0;
			run_over = 1'b0;
			while (!run_over) begin
				len++;
				stepped = 1'b0;
				error_term = error_term - $signed({2'b00, delta_minor});
				if (error_term < 0) begin
					minor_pos = minor_down ? minor_pos + 9'd1 : minor_pos - 9'd1;
					error_term = error_term + $signed({2'b00, delta_major});
					stepped = 1'b1;
				end
				if (major_pos == major_end) begin
					last = 1'b1;
					run_over = 1'b1;
				end else begin
					major_pos++;
					run_over = stepped;
				end
			end
			if (last) begin
				line_active = 1'b0;
			end
			r.x = axes_swapped ? first_minor : first_major;
			r.y = axes_swapped ? first_major : first_minor;
			r.len = len;
			r.vertical = axes_swapped;
			r.color = line_color;
			r.last = last;
			expected_runs.push_back(r);
		endfunction

		task check_run(logic [OUT_W-1:0] data, logic tlast);
			run_t want;
			if (expected_runs.size() == 0) begin
				report($sformatf("unexpected run x=%0d y=%0d len=%0d",
					data[8:0], data[17:9], data[27:18]));
				return;
			end
			want = expected_runs.pop_front();
			if (data[8:0] !== want.x)
				report($sformatf("run_x %0d, expected %0d", data[8:0], want.x));
			if (data[17:9] !== want.y)
				report($sformatf("run_y %0d, expected %0d", data[17:9], want.y));
			if (data[27:18] !== want.len)
				report($sformatf("run_len %0d, expected %0d", data[27:18], want.len));
			if (data[28] !== want.vertical)
				report($sformatf("run_vertical %0b, expected %0b", data[28], want.vertical));
			if (data[44:29] !== want.color)
				report($sformatf("run_color %h, expected %h", data[44:29], want.color));
			if (tlast !== want.last)
				report($sformatf("last_run %0b, expected %0b", tlast, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;

	run_scoreboard sb;
	int items_sent = 0;
	int tx_idle = 21;
	int rx_idle = 48;
	int hold_requests = 0;
	int stall_cycles = 0;

	line_run_rasterizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task send_beat(logic req, logic [8:0] sx, logic [8:0] sy, logic [8:0] ex,
			logic [8:0] ey, logic [15:0] color);
		if (items_sent < 300) begin
			tx_idle = 21;
			rx_idle = 48;
		end else if (items_sent < 600) begin
			tx_idle = 48;
			rx_idle = 21;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {{(IN_W - 52){1'b0}}, color, ey, ex, sy, sx};
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (req == REQ_START || sb.line_active) begin
			items_sent++;
		end
		sb.note_request(req, sx, sy, ex, ey, color);
	endtask

	task send_stray_next();
		send_beat(REQ_NEXT, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom),
			16'($urandom));
	endtask

	task run_line(int sx, int sy, int ex, int ey, logic [15:0] color, int max_next);
		int n;
		n = 0;
		send_beat(REQ_START, 9'(sx), 9'(sy), 9'(ex), 9'(ey), color);
		while (sb.line_active && n < max_next) begin
			send_stray_next();
			n++;
		end
	endtask

	task random_line();
		int span, sx, sy, ex, ey, d, max_next;
		span = $urandom_range(0, 99);
		span = (span < 60) ? 12 : (span < 85) ? 64 : 511;
		sx = $urandom_range(0, 511);
		sy = $urandom_range(0, 511);
		ex = $urandom_range((sx > span) ? sx - span : 0, (sx + span < 511) ? sx + span : 511);
		ey = $urandom_range((sy > span) ? sy - span : 0, (sy + span < 511) ? sy + span : 511);
		case ($urandom_range(0, 9))
			0: ey = sy;
			1: ex = sx;
			2: begin
				d = ($urandom_range(0, 1) == 1) ? ex - sx : sx - ex;
				if (sy + d >= 0 && sy + d <= 511)
					ey = sy + d;
			end
			default: ;
		endcase
		if (span == 511 && $urandom_range(0, 3) != 0)
			max_next = $urandom_range(0, 30);
		else if ($urandom_range(0, 4) == 0)
			max_next = $urandom_range(0, 5);
		else
			max_next = 1000;
		run_line(sx, sy, ex, ey, 16'($urandom), max_next);
		if ($urandom_range(0, 6) == 0 && !sb.line_active) begin
			send_stray_next();
		end
	endtask

	// Result side: checks each beat, then picks tready for the next cycle.
	initial begin
		int hold_left, hold_granted;
		hold_left = 0;
		hold_granted = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_run(m_tdata, m_tlast);
			end
			if (hold_granted != hold_requests) begin
				hold_granted = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		bit pressure_done;
		pressure_done = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_stray_next();
		run_line(0, 0, 0, 0, 16'h0000, 5);
		run_line(511, 511, 511, 511, 16'hFFFF, 5);
		run_line(0, 0, 511, 0, 16'hA5A5, 5);
		run_line(511, 5, 0, 5, 16'h5A5A, 5);
		run_line(3, 0, 3, 511, 16'hF800, 5);
		run_line(0, 0, 3, 3, 16'h07E0, 5);
		run_line(10, 0, 7, 3, 16'h001F, 5);
		run_line(0, 0, 10, 3, 16'h1234, 5);
		send_stray_next();
		run_line(5, 20, 2, 0, 16'hBEEF, 1);
		run_line(0, 511, 511, 510, 16'hC3C3, 5);

		while (items_sent < ITEM_TARGET) begin
			if (!pressure_done && items_sent >= 450) begin
				// The receiver holds off while this line keeps the input busy.
				hold_requests++;
				run_line(100, 100, 140, 140, 16'($urandom), 1000);
				pressure_done = 1'b1;
			end else begin
				random_line();
			end
		end
		s_tvalid <= 1'b0;

		while (sb.expected_runs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_runs.size() != 0) begin
			sb.report($sformatf("%0d runs never arrived", sb.expected_runs.size()));
		end
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
